/* src/sccbm_pkg.sv */
// Shared types and constants for the SCCB master transaction engine.
// No dependencies; used by sccbm_front, sccbm_back and the top level.
`default_nettype none

package sccbm_pkg;

	// config register
	localparam int CFG_W = 16;
	localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd250;

	// defaults for top-level parameters
	localparam int WAIT_WIDTH_DEFAULT = 16;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// bit framing
	localparam logic [3:0] BITS_PER_PHASE = 4'd9;
	localparam logic [3:0] DATA_BITS = 4'd8;

	// classified command
	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	// one queued tick
	typedef struct packed {
		cmd_t       cmd;
		logic [6:0] slave_id;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

endpackage

`default_nettype wire

/* src/sccbm_front.sv */
// Front end: accepts input ticks, classifies the op code and queues them.
// Depends on sccbm_pkg.
`default_nettype none

module sccbm_front #(
	parameter int DEPTH = sccbm_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [6:0]        slave_id,
	input  logic [7:0]        reg_addr,
	input  logic [7:0]        write_data,
	input  logic              sda_in,
	output sccbm_pkg::qhead_t head,
	input  logic              pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sccbm_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	sccbm_pkg::item_t new_item;
	logic             push;

	// op 3 is treated as an idle tick
	always_comb begin
		new_item.slave_id   = slave_id;
		new_item.reg_addr   = reg_addr;
		new_item.write_data = write_data;
		new_item.sda_in     = sda_in;
		unique case (op)
			2'd1:    new_item.cmd = sccbm_pkg::CMD_WRITE;
			2'd2:    new_item.cmd = sccbm_pkg::CMD_READ;
			default: new_item.cmd = sccbm_pkg::CMD_NONE;
		endcase
	end

	assign in_stall   = (count_q == CW'(DEPTH));
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/sccbm_back.sv */
// Back end: bus sequencer with the output register, stepping one queued
// tick per cycle unless out_stall holds it. Depends on sccbm_pkg.
`default_nettype none

module sccbm_back #(
	parameter int WAIT_WIDTH = sccbm_pkg::WAIT_WIDTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sccbm_pkg::qhead_t           head,
	output logic                        pop,
	input  logic                        cfg_write_en,
	input  logic [sccbm_pkg::CFG_W-1:0] cfg_write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        scl,
	output logic                        sda_out,
	output logic                        sda_drive,
	output logic                        busy_res,
	output logic                        done_res,
	output logic [7:0]                  read_data
);

	localparam int CW = sccbm_pkg::CFG_W;

	// stage codes
	localparam logic [2:0] STG_ID_W = 3'd0;
	localparam logic [2:0] STG_ADDR = 3'd1;
	localparam logic [2:0] STG_DATA = 3'd2;
	localparam logic [2:0] STG_ID_R = 3'd3;
	localparam logic [2:0] STG_READ = 3'd4;

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_START   = 7'b0000010,
		PH_BITLO   = 7'b0000100,
		PH_BITHI   = 7'b0001000,
		PH_STOPLO  = 7'b0010000,
		PH_STOPHI  = 7'b0100000,
		PH_STOPEND = 7'b1000000
	} phase_t;

	logic [CW-1:0]         half_q;
	phase_t                phase_q, n_phase;
	logic [2:0]            stage_q, n_stage;
	logic [3:0]            bc_q, n_bc;
	logic [WAIT_WIDTH-1:0] wait_q, n_wait, reload;
	logic [8:0]            shift_q, n_shift;
	logic [7:0]            rshift_q, n_rshift;
	logic [7:0]            rres_q, n_rres;
	logic                  isrd_q, n_isrd;
	logic [6:0]            id_q, n_id;
	logic [7:0]            addr_q, n_addr;
	logic [7:0]            data_q, n_data;
	logic                  n_done;
	logic                  reload_en;
	logic                  reading, n_reading;
	logic [CW-1:0]         hm1;
	logic                  fire;
	logic                  o_scl, o_sda, o_drive;

	logic                  out_valid_q;
	logic                  scl_q, sda_q, drive_q, busy_q, done_q;
	logic [7:0]            rdata_q;

	function automatic logic [8:0] load_shift(input logic [2:0] s, input logic [6:0] id,
			input logic [7:0] addr, input logic [7:0] data);
		unique case (s)
			STG_ID_W: load_shift = {id, 2'b00};
			STG_ADDR: load_shift = {addr, 1'b0};
			STG_DATA: load_shift = {data, 1'b0};
			STG_ID_R: load_shift = {id, 2'b10};
			default:  load_shift = 9'h1FF;
		endcase
	endfunction

	// wait reload: zero behaves as one, long values saturate the counter
	assign hm1    = (half_q == '0) ? '0 : half_q - 1'b1;
	assign reload = (hm1 > CW'({WAIT_WIDTH{1'b1}})) ? '1 : WAIT_WIDTH'(hm1);

	assign fire    = head.valid && (!out_valid_q || !out_stall);
	assign pop     = fire;
	assign reading = (stage_q == STG_READ) && (bc_q < sccbm_pkg::DATA_BITS);

	always_comb begin
		n_phase   = phase_q;
		n_stage   = stage_q;
		n_bc      = bc_q;
		n_wait    = wait_q;
		n_shift   = shift_q;
		n_rshift  = rshift_q;
		n_rres    = rres_q;
		n_isrd    = isrd_q;
		n_id      = id_q;
		n_addr    = addr_q;
		n_data    = data_q;
		n_done    = 1'b0;
		reload_en = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (head.item.cmd != sccbm_pkg::CMD_NONE) begin
				n_id      = head.item.slave_id;
				n_addr    = head.item.reg_addr;
				n_data    = head.item.write_data;
				n_isrd    = (head.item.cmd == sccbm_pkg::CMD_READ);
				n_stage   = STG_ID_W;
				n_bc      = '0;
				n_shift   = load_shift(STG_ID_W, head.item.slave_id, head.item.reg_addr,
					head.item.write_data);
				n_phase   = PH_START;
				reload_en = 1'b1;
			end
		end else if (wait_q != '0) begin
			n_wait = wait_q - 1'b1;
		end else begin
			reload_en = 1'b1;
			unique case (phase_q)
				PH_START:  n_phase = PH_BITLO;
				PH_BITLO:  n_phase = PH_BITHI;
				PH_BITHI: begin
					if (reading) begin
						n_rshift = {rshift_q[6:0], head.item.sda_in};
					end
					n_shift = {shift_q[7:0], 1'b0};
					n_bc    = bc_q + 1'b1;
					if (n_bc < sccbm_pkg::BITS_PER_PHASE) begin
						n_phase = PH_BITLO;
					end else if ((!isrd_q && stage_q < STG_DATA) ||
							(isrd_q && (stage_q == STG_ID_W || stage_q == STG_ID_R))) begin
						n_stage = stage_q + 3'd1;
						n_bc    = '0;
						n_shift = load_shift(n_stage, id_q, addr_q, data_q);
						n_phase = PH_BITLO;
					end else begin
						n_phase = PH_STOPLO;
					end
				end
				PH_STOPLO: n_phase = PH_STOPHI;
				PH_STOPHI: n_phase = PH_STOPEND;
				PH_STOPEND: begin
					if (isrd_q && stage_q == STG_ADDR) begin
						// repeated start for the read half
						n_stage = STG_ID_R;
						n_bc    = '0;
						n_shift = load_shift(STG_ID_R, id_q, addr_q, data_q);
						n_phase = PH_START;
					end else begin
						if (isrd_q) begin
							n_rres = rshift_q;
						end
						n_phase   = PH_IDLE;
						n_done    = 1'b1;
						reload_en = 1'b0;
					end
				end
				PH_IDLE: begin
					n_phase   = PH_IDLE;
					reload_en = 1'b0;
				end
				default: begin
					n_phase   = PH_IDLE;
					reload_en = 1'b0;
				end
			endcase
		end
		if (reload_en) begin
			n_wait = reload;
		end
	end

	// bus levels after this tick
	assign n_reading = (n_stage == STG_READ) && (n_bc < sccbm_pkg::DATA_BITS);

	always_comb begin
		o_drive = 1'b1;
		unique case (n_phase)
			PH_START: begin
				o_scl = 1'b1;
				o_sda = 1'b0;
			end
			PH_BITLO: begin
				o_scl   = 1'b0;
				o_sda   = n_shift[8];
				o_drive = !n_reading;
			end
			PH_BITHI: begin
				o_scl   = 1'b1;
				o_sda   = n_shift[8];
				o_drive = !n_reading;
			end
			PH_STOPLO: begin
				o_scl = 1'b0;
				o_sda = 1'b0;
			end
			PH_STOPHI: begin
				o_scl = 1'b1;
				o_sda = 1'b0;
			end
			default: begin
				o_scl = 1'b1;
				o_sda = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= sccbm_pkg::HALF_PERIOD_RESET;
			phase_q  <= PH_IDLE;
			stage_q  <= STG_ID_W;
			bc_q     <= '0;
			wait_q   <= '0;
			shift_q  <= '0;
			rshift_q <= '0;
			rres_q   <= '0;
			isrd_q   <= 1'b0;
			id_q     <= '0;
			addr_q   <= '0;
			data_q   <= '0;
		end else begin
			if (cfg_write_en) begin
				half_q <= cfg_write_data;
			end
			if (fire) begin
				phase_q  <= n_phase;
				stage_q  <= n_stage;
				bc_q     <= n_bc;
				wait_q   <= n_wait;
				shift_q  <= n_shift;
				rshift_q <= n_rshift;
				rres_q   <= n_rres;
				isrd_q   <= n_isrd;
				id_q     <= n_id;
				addr_q   <= n_addr;
				data_q   <= n_data;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// bus idles high out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			drive_q <= 1'b1;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			rdata_q <= '0;
		end else if (fire) begin
			scl_q   <= o_scl;
			sda_q   <= o_sda;
			drive_q <= o_drive;
			busy_q  <= (n_phase != PH_IDLE);
			done_q  <= n_done;
			rdata_q <= n_rres;
		end
	end

	assign out_valid = out_valid_q;
	assign scl       = scl_q;
	assign sda_out   = sda_q;
	assign sda_drive = drive_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign read_data = rdata_q;

	// a finishing transaction always leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (!busy_q && phase_q == PH_IDLE))
		else $error("done reported while engine busy");

	// a running half-period wait never changes the phase
	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q != PH_IDLE && wait_q != '0) |=> (phase_q == $past(phase_q)))
		else $error("phase moved during half-period wait");

	a_bc_range: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= sccbm_pkg::BITS_PER_PHASE)
		else $error("bit count out of range");

	// SDA is released only while clocking in read data
	a_release_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !drive_q) |-> (stage_q == STG_READ && isrd_q))
		else $error("SDA released outside read data bits");

endmodule

`default_nettype wire

/* src/sccb_master_transaction_engine.sv */
// Top level of the SCCB master transaction engine: front end queue plus
// back-end bus sequencer. Depends on sccbm_pkg, sccbm_front, sccbm_back.
//
// Usage: every input transaction is one tick of the bus engine. op selects
// an idle tick, a register write or a register read; slave_id, reg_addr and
// write_data are latched only when a command starts while the engine is
// idle, and commands seen while busy are dropped. sda_in is the SDA level
// sampled for that tick. Each accepted tick yields exactly one output
// transaction with the bus levels after that tick (scl, sda_out, sda_drive),
// busy_res, a one-tick done_res pulse and the last read byte.
// Throughput: one tick per clock while out_stall does not hold the output
// register; the back end steps one queued tick per cycle unless out_stall
// holds it, so ticks stream back to back. The edge that accepts a tick writes
// it into the queue, then the sequencer steps it into the output register.
// cfg_write_en/cfg_write_data load half_period_cycles (ticks per SCL half);
// the user must write it while the engine is idle; nothing here enforces it.
// Stalls: out_stall holds the output register; ticks keep landing in the
// QUEUE_DEPTH-entry queue, and in_stall rises once it is full.
// Reset (arst_n low) empties the queue, idles the bus (SCL and SDA high),
// clears read_data and restores the half period to 250.
`default_nettype none

module sccb_master_transaction_engine #(
	parameter int WAIT_WIDTH  = sccbm_pkg::WAIT_WIDTH_DEFAULT,
	parameter int QUEUE_DEPTH = sccbm_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [sccbm_pkg::CFG_W-1:0] cfg_write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  op,
	input  logic [6:0]                  slave_id,
	input  logic [7:0]                  reg_addr,
	input  logic [7:0]                  write_data,
	input  logic                        sda_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        scl,
	output logic                        sda_out,
	output logic                        sda_drive,
	output logic                        busy_res,
	output logic                        done_res,
	output logic [7:0]                  read_data
);

	sccbm_pkg::qhead_t head;
	logic              pop;

	// accept and classify ticks into the queue
	sccbm_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.slave_id  (slave_id),
		.reg_addr  (reg_addr),
		.write_data(write_data),
		.sda_in    (sda_in),
		.head      (head),
		.pop       (pop)
	);

	// bus sequencer and output register
	sccbm_back #(
		.WAIT_WIDTH(WAIT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.scl           (scl),
		.sda_out       (sda_out),
		.sda_drive     (sda_drive),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.read_data     (read_data)
	);

endmodule

`default_nettype wire

/* sim/sccb_master_transaction_engine_test.sv */
// Self-checking bench for sccb_master_transaction_engine: a directed table of bus commands,
// then random ticks; every output is checked against the in-bench tick model or a row's want.
// Depends on sccbm_pkg and the engine RTL; no files, no arguments.

module sccb_master_transaction_engine_test;

	// op code that the engine treats as an idle tick
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// how sda_in is filled while a row's transaction runs
	localparam logic [1:0] SDA_FILL_LOW  = 2'd0;
	localparam logic [1:0] SDA_FILL_HIGH = 2'd1;
	localparam logic [1:0] SDA_FILL_RAND = 2'd2;

	// nine-bit frames on the wire
	localparam logic [2:0] FRAME_ID_WR = 3'd0;
	localparam logic [2:0] FRAME_ADDR  = 3'd1;
	localparam logic [2:0] FRAME_DATA  = 3'd2;
	localparam logic [2:0] FRAME_ID_RD = 3'd3;
	localparam logic [2:0] FRAME_READ  = 3'd4;

	// receiver stall patterns
	localparam int RX_FREE   = 0;
	localparam int RX_LIGHT  = 1;
	localparam int RX_HEAVY  = 2;
	localparam int RX_TOGGLE = 3;

	localparam int HOLD_AT     = 600;
	localparam int HOLD_LEN    = 80;
	localparam int RAND_PHASES = 3;
	localparam int RAND_TICKS  = 100;
	localparam int SLOW_TICKS  = 100;
	localparam int PLAN_ROWS   = 14;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 16;
	localparam logic [15:0] HP_SLOWEST = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_BIT_LO,
		PH_BIT_HI,
		PH_STOP_LO,
		PH_STOP_HI,
		PH_STOP_END
	} bus_phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] slave_id;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
	} bus_t;

	typedef struct packed {
		logic [15:0] hp;
		logic [1:0]  op;
		logic [6:0]  slave_id;
		logic [7:0]  reg_addr;
		logic [7:0]  write_data;
		logic [1:0]  fill;
		logic        chk;
		bus_t        want;
	} row_t;

	localparam bus_t BUS_RESET      = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
	localparam bus_t BUS_FIRST_HALF = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00};

	// Directed commands. A row with chk set carries its own expected levels for the
	// command tick; all later ticks of the row come from the tick model.
	row_t plan [PLAN_ROWS] = '{
		'{16'd250, sccbm_pkg::CMD_NONE,  7'h00, 8'h00, 8'h00, SDA_FILL_HIGH, 1'b1, BUS_RESET},
		'{16'd250, OP_RESERVED,          7'h7F, 8'hFF, 8'hFF, SDA_FILL_LOW,  1'b1, BUS_RESET},
		'{16'd1,   sccbm_pkg::CMD_WRITE, 7'h7F, 8'hFF, 8'hFF, SDA_FILL_RAND, 1'b1,
			BUS_FIRST_HALF},
		'{16'd1,   sccbm_pkg::CMD_NONE,  7'h00, 8'h00, 8'h00, SDA_FILL_RAND, 1'b1, BUS_RESET},
		'{16'd0,   sccbm_pkg::CMD_WRITE, 7'h00, 8'h00, 8'h00, SDA_FILL_RAND, 1'b0, '0},
		'{16'd0,   sccbm_pkg::CMD_READ,  7'h7F, 8'hFF, 8'h00, SDA_FILL_HIGH, 1'b0, '0},
		'{16'd0,   sccbm_pkg::CMD_READ,  7'h00, 8'h00, 8'hFF, SDA_FILL_LOW,  1'b0, '0},
		'{16'd1,   sccbm_pkg::CMD_READ,  7'h00, 8'h00, 8'hFF, SDA_FILL_HIGH, 1'b0, '0},
		'{16'd1,   sccbm_pkg::CMD_WRITE, 7'h55, 8'hAA, 8'h55, SDA_FILL_RAND, 1'b0, '0},
		'{16'd1,   sccbm_pkg::CMD_READ,  7'h2A, 8'h55, 8'hAA, SDA_FILL_LOW,  1'b0, '0},
		'{16'd2,   sccbm_pkg::CMD_WRITE, 7'h2A, 8'h55, 8'hAA, SDA_FILL_RAND, 1'b0, '0},
		'{16'd2,   sccbm_pkg::CMD_READ,  7'h55, 8'hAA, 8'h55, SDA_FILL_RAND, 1'b0, '0},
		'{16'd3,   OP_RESERVED,          7'h00, 8'h00, 8'h00, SDA_FILL_RAND, 1'b0, '0},
		'{16'd3,   sccbm_pkg::CMD_READ,  7'h7F, 8'h00, 8'hFF, SDA_FILL_RAND, 1'b0, '0}
	};

	logic                        clk            = 1'b0;
	logic                        arst_n         = 1'b0;
	logic                        cfg_write_en   = 1'b0;
	logic [sccbm_pkg::CFG_W-1:0] cfg_write_data = sccbm_pkg::HALF_PERIOD_RESET;
	logic                        in_valid       = 1'b0;
	logic [1:0]                  op             = 2'd0;
	logic [6:0]                  slave_id       = 7'd0;
	logic [7:0]                  reg_addr       = 8'd0;
	logic [7:0]                  write_data     = 8'd0;
	logic                        sda_in         = 1'b1;
	logic                        out_stall      = 1'b0;
	logic                        in_stall;
	logic                        out_valid;
	logic                        scl;
	logic                        sda_out;
	logic                        sda_drive;
	logic                        busy_res;
	logic                        done_res;
	logic [7:0]                  read_data;

	sccb_master_transaction_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.slave_id       (slave_id),
		.reg_addr       (reg_addr),
		.write_data     (write_data),
		.sda_in         (sda_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.scl            (scl),
		.sda_out        (sda_out),
		.sda_drive      (sda_drive),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.read_data      (read_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

	// ---- tick model of the bus sequencer ----
	logic [15:0] hp_cfg;
	bus_phase_t  bus_ph;
	logic [2:0]  frame;
	logic [3:0]  nbit;
	logic [15:0] wcnt;
	logic [8:0]  sreg;
	logic [7:0]  rshift;
	logic [7:0]  rbyte;
	logic        is_rd;
	logic [6:0]  held_id;
	logic [7:0]  held_addr;
	logic [7:0]  held_data;

	bus_t pending_levels [$];
	int   fails      = 0;
	int   burst_left = 0;

	function automatic void load_frame(input logic [2:0] f);
		frame = f;
		nbit = 4'd0;
		case (f)
			FRAME_ID_WR: sreg = {held_id, 2'b00};
			FRAME_ADDR:  sreg = {held_addr, 1'b0};
			FRAME_DATA:  sreg = {held_data, 1'b0};
			FRAME_ID_RD: sreg = {held_id, 2'b10};   // R/W bit set
			default:     sreg = 9'h1FF;             // read byte, NA bit high
		endcase
	endfunction

	function automatic logic sampling_bit();
		return frame == FRAME_READ && nbit < sccbm_pkg::DATA_BITS;
	endfunction

	// a zero half period behaves like a setting of one
	function automatic void arm_half();
		wcnt = (hp_cfg == 16'd0) ? 16'd0 : hp_cfg - 16'd1;
	endfunction

	// move to the next half period; true when the transaction has ended
	function automatic logic next_half(input logic sda);
		logic ended;
		ended = 1'b0;
		case (bus_ph)
			PH_START:   bus_ph = PH_BIT_LO;
			PH_BIT_LO:  bus_ph = PH_BIT_HI;
			PH_BIT_HI: begin
				if (sampling_bit())
					rshift = {rshift[6:0], sda};
				sreg = {sreg[7:0], 1'b0};
				nbit = nbit + 4'd1;
				if (nbit < sccbm_pkg::BITS_PER_PHASE) begin
					bus_ph = PH_BIT_LO;
				end else if (!is_rd && frame < FRAME_DATA) begin
					load_frame(frame + 3'd1);
					bus_ph = PH_BIT_LO;
				end else if (is_rd && (frame == FRAME_ID_WR || frame == FRAME_ID_RD)) begin
					load_frame(frame + 3'd1);
					bus_ph = PH_BIT_LO;
				end else begin
					bus_ph = PH_STOP_LO;
				end
			end
			PH_STOP_LO: bus_ph = PH_STOP_HI;
			PH_STOP_HI: bus_ph = PH_STOP_END;
			default: begin
				// a read turns around after its address frame: restart with the ID, R/W bit set
				if (is_rd && frame == FRAME_ADDR) begin
					load_frame(FRAME_ID_RD);
					bus_ph = PH_START;
				end else begin
					if (is_rd)
						rbyte = rshift;
					bus_ph = PH_IDLE;
					ended = 1'b1;
				end
			end
		endcase
		if (!ended)
			arm_half();
		return ended;
	endfunction

	// levels on the output for one accepted tick
	function automatic bus_t levels_after(input tick_t t);
		bus_t lv;
		logic bitv;
		lv = '0;
		lv.sda_drive = 1'b1;
		if (bus_ph == PH_IDLE) begin
			if (t.op == sccbm_pkg::CMD_WRITE || t.op == sccbm_pkg::CMD_READ) begin
				held_id = t.slave_id;
				held_addr = t.reg_addr;
				held_data = t.write_data;
				is_rd = (t.op == sccbm_pkg::CMD_READ);
				load_frame(FRAME_ID_WR);
				bus_ph = PH_START;
				arm_half();
			end
		end else if (wcnt != 16'd0) begin
			wcnt = wcnt - 16'd1;
		end else begin
			lv.done = next_half(t.sda_in);
		end
		bitv = sreg[8];
		case (bus_ph)
			PH_START: begin
				lv.scl = 1'b1;
				lv.sda_out = 1'b0;
			end
			PH_BIT_LO: begin
				lv.scl = 1'b0;
				lv.sda_out = bitv;
				lv.sda_drive = !sampling_bit();
			end
			PH_BIT_HI: begin
				lv.scl = 1'b1;
				lv.sda_out = bitv;
				lv.sda_drive = !sampling_bit();
			end
			PH_STOP_LO: begin
				lv.scl = 1'b0;
				lv.sda_out = 1'b0;
			end
			PH_STOP_HI: begin
				lv.scl = 1'b1;
				lv.sda_out = 1'b0;
			end
			default: begin
				lv.scl = 1'b1;
				lv.sda_out = 1'b1;
			end
		endcase
		lv.busy = (bus_ph != PH_IDLE);
		lv.rdata = rbyte;
		return lv;
	endfunction

	// ---- sender ----
	// Bursts of back-to-back ticks with random gaps between them. The model is
	// stepped at the edge the tick is accepted.
	task automatic send_tick(input tick_t t, input logic chk, input bus_t want);
		bus_t lv;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 64);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		op         <= t.op;
		slave_id   <= t.slave_id;
		reg_addr   <= t.reg_addr;
		write_data <= t.write_data;
		sda_in     <= t.sda_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		lv = levels_after(t);
		pending_levels.push_back(chk ? want : lv);
	endtask

	// fill LOW/HIGH map onto bit 0
	function automatic tick_t rand_tick(input logic [1:0] fill);
		tick_t t;
		t.op = 2'($urandom_range(0, 3));
		t.slave_id = 7'($urandom);
		t.reg_addr = 8'($urandom);
		t.write_data = 8'($urandom);
		t.sda_in = (fill == SDA_FILL_RAND) ? 1'($urandom_range(0, 1)) : fill[0];
		return t;
	endfunction

	// keep ticking (commands here are dropped as busy) until the bus goes idle
	task automatic run_to_idle(input logic [1:0] fill);
		while (bus_ph != PH_IDLE)
			send_tick(rand_tick(fill), 1'b0, '0);
	endtask

	// only written with the engine idle and every output collected
	task automatic write_half_period(input logic [15:0] v);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		hp_cfg = v;
	endtask

	// ---- receiver stall pattern ----
	int cyc        = 0;
	int hold_left  = 0;
	int hold_done  = 0;
	int mode_left  = 0;
	int stall_mode = RX_FREE;

	always @(posedge clk) begin
		cyc++;
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if ((cyc >= HOLD_AT && hold_done == 0 && in_valid) ||
				$urandom_range(0, 7999) == 0) begin
			// long hold-off: the sender keeps offering, so the queue fills and in_stall rises
			hold_done = 1;
			hold_left = HOLD_LEN - 1;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(RX_FREE, RX_TOGGLE);
				mode_left = $urandom_range(16, 400);
			end
			mode_left--;
			case (stall_mode)
				RX_LIGHT:  out_stall <= ($urandom_range(0, 7) == 0);
				RX_HEAVY:  out_stall <= ($urandom_range(0, 1) == 0);
				RX_TOGGLE: out_stall <= !out_stall;
				default:   out_stall <= 1'b0;
			endcase
		end
	end

	// ---- output check ----
	always @(posedge clk) begin
		bus_t got;
		bus_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{scl, sda_out, sda_drive, busy_res, done_res, read_data};
			if (pending_levels.size() == 0) begin
				fails++;
				if (fails <= MAX_REPORTS)
					$display("%0t: output transaction with nothing pending", $realtime);
			end else begin
				want = pending_levels.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= MAX_REPORTS) begin
						$display("%0t: exp scl=%b sda=%b drv=%b busy=%b done=%b rd=%h",
							$realtime, want.scl, want.sda_out, want.sda_drive, want.busy,
							want.done, want.rdata);
						$display("%0t: got scl=%b sda=%b drv=%b busy=%b done=%b rd=%h",
							$realtime, got.scl, got.sda_out, got.sda_drive, got.busy,
							got.done, got.rdata);
					end
				end
			end
		end
	end

	// ---- stimulus ----
	initial begin
		tick_t t;
		int sel;
		logic [15:0] hp_next;

		hp_cfg = sccbm_pkg::HALF_PERIOD_RESET;
		bus_ph = PH_IDLE;
		frame = FRAME_ID_WR;
		nbit = 4'd0;
		wcnt = 16'd0;
		sreg = 9'd0;
		rshift = 8'd0;
		rbyte = 8'd0;
		is_rd = 1'b0;
		held_id = 7'd0;
		held_addr = 8'd0;
		held_data = 8'd0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of every field, both commands, reserved op,
		// zero / default half periods, all-ones and all-zeros read bytes
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].hp != hp_cfg)
				write_half_period(plan[r].hp);
			t.op = plan[r].op;
			t.slave_id = plan[r].slave_id;
			t.reg_addr = plan[r].reg_addr;
			t.write_data = plan[r].write_data;
			t.sda_in = (plan[r].fill == SDA_FILL_RAND) ? 1'($urandom_range(0, 1)) :
				plan[r].fill[0];
			send_tick(t, plan[r].chk, plan[r].want);
			run_to_idle(plan[r].fill);
		end

		// random: mostly well-formed commands issued as soon as the bus is idle,
		// with dropped commands and reserved ops thrown in while it is busy
		for (int k = 0; k < RAND_PHASES; k++) begin
			hp_next = (k == 0) ? 16'd1 : 16'($urandom_range(1, 3));
			write_half_period(hp_next);
			for (int n = 0; n < RAND_TICKS; n++) begin
				t = rand_tick(SDA_FILL_RAND);
				if (bus_ph == PH_IDLE) begin
					sel = $urandom_range(0, 19);
					if (sel < 17)
						t.op = sel[0] ? sccbm_pkg::CMD_READ : sccbm_pkg::CMD_WRITE;
				end
				send_tick(t, 1'b0, '0);
			end
			run_to_idle(SDA_FILL_RAND);
		end

		// longest half period: only the start of one write fits in the run
		write_half_period(HP_SLOWEST);
		t = rand_tick(SDA_FILL_RAND);
		t.op = sccbm_pkg::CMD_WRITE;
		send_tick(t, 1'b0, '0);
		repeat (SLOW_TICKS)
			send_tick(rand_tick(SDA_FILL_RAND), 1'b0, '0);

		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sccb_master_transaction_engine.f */
src/sccbm_pkg.sv
src/sccbm_front.sv
src/sccbm_back.sv
src/sccb_master_transaction_engine.sv
sim/sccb_master_transaction_engine_test.sv
